// ===== design/assert_macros.svh =====
// Assertion macros shared by the lattice filter RTL.
// Included by files that assert; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Immediate-consequence property, checked on each rising clock edge.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle property: ante at one edge implies cons at the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/lapsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants, microcode table and arithmetic helpers
// for the lattice all-pole synthesis filter. No dependencies.
package lapsf_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int COEFF_W       = 16;
    localparam int INDEX_W       = 4;
    localparam int ORDER_W       = 5;
    localparam int PROD_W        = SAMPLE_W + COEFF_W;
    localparam int FRAC_SHIFT    = 15;
    localparam int ROUND_HALF    = 1 << (FRAC_SHIFT - 1);
    localparam int MAX_ORDER_DEF = 16;
    localparam int ORDER_RESET   = 5;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;
    localparam int PC_W          = 3;

    // Item commands
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEFF  = 1'b1;

    // Register index (word address)
    localparam logic [APB_AW-3:0] REG_ORDER = '0;

    // Microcode step addresses
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_READ = 3'd1;
    localparam logic [PC_W-1:0] PC_MULB = 3'd2;
    localparam logic [PC_W-1:0] PC_SUBF = 3'd3;
    localparam logic [PC_W-1:0] PC_MULF = 3'd4;
    localparam logic [PC_W-1:0] PC_UPDB = 3'd5;
    localparam logic [PC_W-1:0] PC_FIN  = 3'd6;

    // Jump conditions
    localparam logic [2:0] JC_NEXT  = 3'd0;
    localparam logic [2:0] JC_START = 3'd1;
    localparam logic [2:0] JC_ORD0  = 3'd2;
    localparam logic [2:0] JC_STNZ  = 3'd3;
    localparam logic [2:0] JC_FREE  = 3'd4;

    // Memory read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_ST   = 2'd1;
    localparam logic [1:0] RD_STM1 = 2'd2;

    typedef struct packed {
        logic            idle;
        logic            ld;
        logic [1:0]      rd;
        logic            mul_en;
        logic            mul_sel;
        logic            f_sub;
        logic            b_upd;
        logic            st_dec;
        logic            fin;
        logic [2:0]      jc;
        logic [PC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic       idle;
        logic       ld;
        logic [1:0] rd;
        logic       mul_en;
        logic       mul_sel;
        logic       f_sub;
        logic       b_upd;
        logic       st_dec;
        logic       fin;
        logic       go;
    } t_ctl;

    typedef struct packed {
        logic start;
        logic ord_zero;
        logic st_nz;
        logic out_free;
    } t_cond;

    typedef struct packed {
        logic ord_zero;
        logic st_nz;
    } t_dstat;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            PC_IDLE: begin
                w.idle = 1'b1;
                w.ld   = 1'b1;
                w.jc   = JC_START;
                w.tgt  = PC_READ;
            end
            PC_READ: begin
                w.rd  = RD_ST;
                w.jc  = JC_ORD0;
                w.tgt = PC_FIN;
            end
            PC_MULB: begin
                w.mul_en = 1'b1;
                w.jc     = JC_NEXT;
            end
            PC_SUBF: begin
                w.f_sub = 1'b1;
                w.jc    = JC_NEXT;
            end
            PC_MULF: begin
                w.mul_en  = 1'b1;
                w.mul_sel = 1'b1;
                w.jc      = JC_NEXT;
            end
            PC_UPDB: begin
                w.b_upd  = 1'b1;
                w.st_dec = 1'b1;
                w.rd     = RD_STM1;
                w.jc     = JC_STNZ;
                w.tgt    = PC_MULB;
            end
            PC_FIN: begin
                w.fin = 1'b1;
                w.jc  = JC_FREE;
                w.tgt = PC_IDLE;
            end
            default: begin
                w.jc  = JC_NEXT;
            end
        endcase
        return w;
    endfunction

    // Clamp a two-bit-grown sum to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SAMPLE_W+1:0] x
    );
        logic signed [SAMPLE_W-1:0] y;
        if (x[SAMPLE_W+1:SAMPLE_W-1] == 3'b000 || x[SAMPLE_W+1:SAMPLE_W-1] == 3'b111) begin
            y = x[SAMPLE_W-1:0];
        end else if (x[SAMPLE_W+1]) begin
            y = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            y = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return y;
    endfunction

    // Round a Q2.38 product to Q2.23, half up.
    function automatic logic signed [SAMPLE_W:0] round_prod(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(ROUND_HALF);
        return t[PROD_W-1:FRAC_SHIFT];
    endfunction

endpackage

// ===== design/lapsf_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for filter items and results.
// Depends on lapsf_pkg for field widths.
interface lapsf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic signed [lapsf_pkg::SAMPLE_W-1:0] sample_in;
    logic                                  restart;
    logic        [lapsf_pkg::INDEX_W-1:0]  coeff_index;
    logic signed [lapsf_pkg::COEFF_W-1:0]  coeff_value;

    modport source (output valid, command, sample_in, restart, coeff_index, coeff_value,
                    input ready);
    modport sink   (input valid, command, sample_in, restart, coeff_index, coeff_value,
                    output ready);
endinterface

interface lapsf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lapsf_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

// ===== design/lattice_all_pole_synthesis_filter.sv =====
`timescale 1ns / 1ps
// Top level of the lattice all-pole synthesis filter: channels, APB
// register, output register. Depends on lapsf_pkg, lapsf_ifs, lapsf_seq, lapsf_dp, assert_macros.svh.
//
// Usage:
//   i_in carries items. command = filter: sample_in is run through the
//   lattice from stage order-1 down to 0 and one sample_out item results;
//   restart = 1 clears the backward memory first. command = coefficient:
//   coeff_value is stored at stage coeff_index, no result.
//   o_out carries results from an output register.
//   APB register 0 (byte 0) holds filter_order, reset 5, clamped to
//   MAX_ORDER when used.
// Sequence:
//   A filter item runs each stage on one shared multiplier through the steps
//   multiply, subtract, multiply and update, after a read step and before a
//   finish step that loads the output register; no new item is taken until
//   the sequencer is back in its idle step.
//   Coefficient items are written without leaving the idle step.
// Reset returns the step counter to idle and the order register to 5, and
// clears the output valid and the memory valid bits, so all coefficients and
// backward values read zero. No item is taken while reset is held.
// When the receiver stalls, the finish step holds until the output
// register frees; a new item can be taken while a result waits.
`include "assert_macros.svh"

module lattice_all_pole_synthesis_filter #(
    parameter int MAX_ORDER = lapsf_pkg::MAX_ORDER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lapsf_in_if.sink                      i_in,
    lapsf_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lapsf_pkg::APB_AW-1:0]  paddr,
    input  logic [lapsf_pkg::APB_DW-1:0]  pwdata,
    output logic [lapsf_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    logic [lapsf_pkg::ORDER_W-1:0]         r_order;
    logic                                  r_out_valid;
    logic signed [lapsf_pkg::SAMPLE_W-1:0] r_out_data;

    lapsf_pkg::t_ctl                       ctl;
    lapsf_pkg::t_cond                      cond;
    lapsf_pkg::t_dstat                     dstat;
    logic signed [lapsf_pkg::SAMPLE_W-1:0] f_val;

    logic sample_acc;
    logic coef_acc;
    logic out_free;
    logic fin_go;
    logic reg_sel;

    // Items are taken only while the sequencer sits in its idle step.
    assign i_in.ready = ctl.idle && i_rst_n;
    assign sample_acc = i_in.valid && i_in.ready && (i_in.command == lapsf_pkg::CMD_FILTER);
    assign coef_acc   = i_in.valid && i_in.ready && (i_in.command == lapsf_pkg::CMD_COEFF);

    // The output slot is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || o_out.ready;
    assign fin_go   = ctl.fin && ctl.go;

    assign cond = '{start: i_in.valid && (i_in.command == lapsf_pkg::CMD_FILTER),
                    ord_zero: dstat.ord_zero, st_nz: dstat.st_nz, out_free: out_free};

    lapsf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctl   (ctl)
    );

    lapsf_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_order    (r_order),
        .i_sample   (i_in.sample_in),
        .i_restart  (i_in.restart),
        .i_coef_we  (coef_acc),
        .i_coef_idx (i_in.coeff_index),
        .i_coef_val (i_in.coeff_value),
        .o_stat     (dstat),
        .o_f        (f_val)
    );

    // APB register file: a single order register at word 0.
    assign reg_sel = (paddr[lapsf_pkg::APB_AW-1:2] == lapsf_pkg::REG_ORDER);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? lapsf_pkg::APB_DW'(r_order) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= lapsf_pkg::ORDER_W'(lapsf_pkg::ORDER_RESET);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_order <= pwdata[lapsf_pkg::ORDER_W-1:0];
        end
    end

    // Output register: load at the finish step, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_data <= f_val;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    `ASSERT_NEXT(a_busy_after_sample, i_clk, i_rst_n, sample_acc, !i_in.ready, "sample item did not start the sequencer")
    `ASSERT_NEXT(a_idle_after_coef, i_clk, i_rst_n, coef_acc, i_in.ready, "coefficient item left the idle step")
    `ASSERT_CLK(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(fin_go), "result raised outside the finish step")

endmodule

// ===== design/lapsf_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on lapsf_pkg for the control word and step codes.
module lapsf_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lapsf_pkg::t_cond i_cond,
    output lapsf_pkg::t_ctl  o_ctl
);

    logic [lapsf_pkg::PC_W-1:0] r_pc;
    logic [lapsf_pkg::PC_W-1:0] n_pc;
    lapsf_pkg::t_uword          uw;
    logic                       go;

    assign uw = lapsf_pkg::ucode(r_pc);

    always_comb begin
        go   = 1'b0;
        n_pc = r_pc;
        case (uw.jc)
            lapsf_pkg::JC_NEXT: begin
                go   = 1'b1;
                n_pc = r_pc + 3'd1;
            end
            lapsf_pkg::JC_START: begin
                go   = i_cond.start;
                n_pc = go ? uw.tgt : r_pc;
            end
            lapsf_pkg::JC_ORD0: begin
                go   = i_cond.ord_zero;
                n_pc = go ? uw.tgt : r_pc + 3'd1;
            end
            lapsf_pkg::JC_STNZ: begin
                go   = i_cond.st_nz;
                n_pc = go ? uw.tgt : r_pc + 3'd1;
            end
            lapsf_pkg::JC_FREE: begin
                go   = i_cond.out_free;
                n_pc = go ? uw.tgt : r_pc;
            end
            default: begin
                go   = 1'b0;
                n_pc = lapsf_pkg::PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lapsf_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = '{idle: uw.idle, ld: uw.ld, rd: uw.rd, mul_en: uw.mul_en,
                     mul_sel: uw.mul_sel, f_sub: uw.f_sub, b_upd: uw.b_upd,
                     st_dec: uw.st_dec, fin: uw.fin, go: go};

endmodule

// ===== design/lapsf_dp.sv =====
`timescale 1ns / 1ps
// Lattice datapath: coefficient and backward memories, multiplier,
// rounding and saturation. Depends on lapsf_pkg; driven by lapsf_seq.
module lapsf_dp #(
    parameter int MAX_ORDER = lapsf_pkg::MAX_ORDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lapsf_pkg::t_ctl                       i_ctl,
    input  logic        [lapsf_pkg::ORDER_W-1:0]  i_order,
    input  logic signed [lapsf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                  i_restart,
    input  logic                                  i_coef_we,
    input  logic        [lapsf_pkg::INDEX_W-1:0]  i_coef_idx,
    input  logic signed [lapsf_pkg::COEFF_W-1:0]  i_coef_val,
    output lapsf_pkg::t_dstat                     o_stat,
    output logic signed [lapsf_pkg::SAMPLE_W-1:0] o_f
);

    localparam int SW  = lapsf_pkg::SAMPLE_W;
    localparam int IW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW  = ($clog2(MAX_ORDER + 1) > lapsf_pkg::ORDER_W) ?
                         $clog2(MAX_ORDER + 1) : lapsf_pkg::ORDER_W;
    localparam int CIW = ((IW > lapsf_pkg::INDEX_W) ? IW : lapsf_pkg::INDEX_W) + 1;

    logic signed [SW-1:0]                   bmem [MAX_ORDER];
    logic signed [lapsf_pkg::COEFF_W-1:0]   kmem [MAX_ORDER];
    logic [MAX_ORDER-1:0]                   r_bvalid;
    logic [MAX_ORDER-1:0]                   r_kvalid;

    logic signed [SW-1:0]                   r_f;
    logic signed [lapsf_pkg::PROD_W-1:0]    r_p;
    logic [IW-1:0]                          r_st;
    logic signed [SW-1:0]                   r_bq;
    logic                                   r_bv;
    logic signed [lapsf_pkg::COEFF_W-1:0]   r_kq;
    logic                                   r_kv;

    logic [CW-1:0]                          ord_ext;
    logic [CW-1:0]                          ord_eff;
    logic [IW:0]                            st_p1;
    logic                                   top_ok;
    logic [IW-1:0]                          rd_addr;
    logic                                   rd_en;
    logic signed [SW-1:0]                   b_eff;
    logic signed [lapsf_pkg::COEFF_W-1:0]   k_eff;
    logic signed [SW-1:0]                   mul_a;
    logic signed [SW:0]                     rnd_p;
    logic                                   ld_go;
    logic                                   b_we;
    logic [IW-1:0]                          b_wa;
    logic signed [SW-1:0]                   b_wd;
    logic                                   k_we;

    assign ord_ext = CW'(i_order);
    assign ord_eff = (ord_ext > CW'(MAX_ORDER)) ? CW'(MAX_ORDER) : ord_ext;
    assign st_p1   = {1'b0, r_st} + (IW+1)'(1);
    assign top_ok  = st_p1 < (IW+1)'(MAX_ORDER);

    assign rd_en   = (i_ctl.rd != lapsf_pkg::RD_NONE);
    assign rd_addr = (i_ctl.rd == lapsf_pkg::RD_STM1) ? r_st - IW'(1) : r_st;

    // Entries never written since reset, or backward entries since restart, read as zero.
    assign b_eff = r_bv ? r_bq : '0;
    assign k_eff = r_kv ? r_kq : '0;
    assign mul_a = i_ctl.mul_sel ? r_f : b_eff;
    assign rnd_p = lapsf_pkg::round_prod(r_p);

    assign ld_go = i_ctl.ld && i_ctl.go;
    assign b_we  = (i_ctl.b_upd && top_ok) || (i_ctl.fin && i_ctl.go);
    assign b_wa  = i_ctl.b_upd ? st_p1[IW-1:0] : '0;
    assign b_wd  = i_ctl.b_upd ?
                   lapsf_pkg::sat_sample({{2{b_eff[SW-1]}}, b_eff} + {rnd_p[SW], rnd_p}) :
                   r_f;
    assign k_we  = i_coef_we && (CIW'(i_coef_idx) < CIW'(MAX_ORDER));

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            bmem[b_wa] <= b_wd;
        end
        if (k_we) begin
            kmem[IW'(i_coef_idx)] <= i_coef_val;
        end
        if (rd_en) begin
            r_bq <= bmem[rd_addr];
            r_kq <= kmem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= '0;
            r_kvalid <= '0;
            r_bv     <= 1'b0;
            r_kv     <= 1'b0;
        end else begin
            if (ld_go && i_restart) begin
                r_bvalid <= '0;
            end else if (b_we) begin
                r_bvalid[b_wa] <= 1'b1;
            end
            if (k_we) begin
                r_kvalid[IW'(i_coef_idx)] <= 1'b1;
            end
            if (rd_en) begin
                r_bv <= r_bvalid[rd_addr];
                r_kv <= r_kvalid[rd_addr];
            end
        end
    end

    // Forward value, product register and stage counter.
    always_ff @(posedge i_clk) begin
        if (ld_go) begin
            r_f  <= i_sample;
            r_st <= IW'(ord_eff - CW'(1));
        end else begin
            if (i_ctl.f_sub) begin
                r_f <= lapsf_pkg::sat_sample({{2{r_f[SW-1]}}, r_f} - {rnd_p[SW], rnd_p});
            end
            if (i_ctl.st_dec) begin
                r_st <= r_st - IW'(1);
            end
        end
        if (i_ctl.mul_en) begin
            r_p <= mul_a * k_eff;
        end
    end

    assign o_stat.ord_zero = (i_order == '0);
    assign o_stat.st_nz    = (r_st != '0);
    assign o_f             = r_f;

endmodule

// ===== verif/lapsf_filter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the lattice all-pole synthesis filter: snoops the item, result
// and APB channels and compares sample_out with its own lattice prediction.
// Depends on lapsf_pkg and the lapsf_in_if / lapsf_out_if interfaces.
module lapsf_filter_checker #(
    parameter int MAX_STAGES = lapsf_pkg::MAX_ORDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    lapsf_in_if                                   i_items,
    lapsf_out_if                                  i_results,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic                                  i_pready,
    input  logic [lapsf_pkg::APB_AW-1:0]          i_paddr,
    input  logic [lapsf_pkg::APB_DW-1:0]          i_pwdata,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    localparam longint SAMPLE_HI = (64'sd1 <<< (lapsf_pkg::SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -(64'sd1 <<< (lapsf_pkg::SAMPLE_W - 1));

    logic signed [lapsf_pkg::SAMPLE_W-1:0] back_mem [MAX_STAGES];
    logic signed [lapsf_pkg::COEFF_W-1:0]  refl     [MAX_STAGES];
    logic        [lapsf_pkg::ORDER_W-1:0]  order_reg;
    logic signed [lapsf_pkg::SAMPLE_W-1:0] sample_q [$];

    // Q1.23 x Q1.15 -> Q2.23, round half up (floor after adding half an LSB).
    function automatic longint round_mul(input longint a, input longint k);
        return (a * k + longint'(lapsf_pkg::ROUND_HALF)) >>> lapsf_pkg::FRAC_SHIFT;
    endfunction

    function automatic longint clamp_sample(input longint x);
        if (x > SAMPLE_HI) return SAMPLE_HI;
        if (x < SAMPLE_LO) return SAMPLE_LO;
        return x;
    endfunction

    // Run one sample down the lattice from the top stage in use to stage 0.
    function automatic logic signed [lapsf_pkg::SAMPLE_W-1:0] run_lattice(
        input logic signed [lapsf_pkg::SAMPLE_W-1:0] x,
        input logic                                  clear
    );
        int     stages;
        longint fwd;
        longint bk;
        longint kc;
        if (clear) begin
            foreach (back_mem[i]) back_mem[i] = '0;
        end
        stages = (int'(order_reg) > MAX_STAGES) ? MAX_STAGES : int'(order_reg);
        fwd = x;
        for (int st = stages - 1; st >= 0; st--) begin
            kc  = refl[st];
            bk  = back_mem[st];
            fwd = clamp_sample(fwd - round_mul(bk, kc));
            if (st + 1 < MAX_STAGES) begin
                back_mem[st+1] = lapsf_pkg::SAMPLE_W'(clamp_sample(bk + round_mul(fwd, kc)));
            end
        end
        back_mem[0] = lapsf_pkg::SAMPLE_W'(fwd);
        return lapsf_pkg::SAMPLE_W'(fwd);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (back_mem[i]) back_mem[i] = '0;
            foreach (refl[i]) refl[i] = '0;
            order_reg = lapsf_pkg::ORDER_W'(lapsf_pkg::ORDER_RESET);
            sample_q.delete();
        end else begin
            // Results first: a result at this edge belongs to an older item.
            if (i_results.valid && i_results.ready) begin
                if (sample_q.size() == 0) begin
                    $error("sample_out: unexpected result %0d", i_results.sample_out);
                    o_fail_count++;
                end else if (i_results.sample_out !== sample_q[0]) begin
                    $error("sample_out mismatch: expected %0d, got %0d",
                           sample_q[0], i_results.sample_out);
                    o_fail_count++;
                    void'(sample_q.pop_front());
                end else begin
                    void'(sample_q.pop_front());
                end
            end
            if (i_items.valid && i_items.ready) begin
                if (i_items.command == lapsf_pkg::CMD_COEFF) begin
                    if (int'(i_items.coeff_index) < MAX_STAGES) begin
                        refl[i_items.coeff_index] = i_items.coeff_value;
                    end
                end else begin
                    sample_q.push_back(run_lattice(i_items.sample_in, i_items.restart));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[lapsf_pkg::APB_AW-1:2] == lapsf_pkg::REG_ORDER) begin
                order_reg = i_pwdata[lapsf_pkg::ORDER_W-1:0];
            end
        end
        o_pending = sample_q.size();
    end

endmodule

// ===== verif/tb_lattice_all_pole_synthesis_filter.sv =====
`timescale 1ns / 1ps
// Testbench top for the lattice all-pole synthesis filter: clock, reset,
// stimulus, APB order writes and the verdict. Depends on lapsf_pkg, the
// channel interfaces, lapsf_filter_checker and the filter RTL.
module tb_lattice_all_pole_synthesis_filter;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    // Wait after the last result, with margin for a trailing finish step.
    localparam int SETTLE_CYCLES = 100;
    localparam int ITEMS_PER_PHASE = 112;

    logic clk = 1'b0;
    logic rst_n;

    lapsf_in_if  item_ch ();
    lapsf_out_if result_ch ();

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lapsf_pkg::APB_AW-1:0]   paddr;
    logic [lapsf_pkg::APB_DW-1:0]   pwdata;
    logic [lapsf_pkg::APB_DW-1:0]   prdata;
    logic                           pready;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;

    always #HALF_PERIOD clk = ~clk;

    lattice_all_pole_synthesis_filter i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (item_ch),
        .o_out   (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lapsf_filter_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_items      (item_ch),
        .i_results    (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: drop ready at random, per cycle, so stalls land on every
    // phase of the lattice sequence, including a result waiting in the
    // output register while the next item is taken.
    always @(negedge clk) begin
        result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Drive one item. Hold valid high across the acceptance edge; the next
    // call (or quiesce) decides at the following falling edge whether it
    // stays high with new content or drops.
    task automatic send_item(
        input logic                                  cmd,
        input logic signed [lapsf_pkg::SAMPLE_W-1:0] smp,
        input logic                                  clr,
        input logic        [lapsf_pkg::INDEX_W-1:0]  idx,
        input logic signed [lapsf_pkg::COEFF_W-1:0]  kval
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid     = 1'b0;
            item_ch.sample_in = lapsf_pkg::SAMPLE_W'($urandom);
            @(negedge clk);
        end
        item_ch.command     = cmd;
        item_ch.sample_in   = smp;
        item_ch.restart     = clr;
        item_ch.coeff_index = idx;
        item_ch.coeff_value = kval;
        item_ch.valid       = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Build a random item. Most are samples with random content; coefficient
    // loads are mixed in so the lattice keeps changing under the samples.
    // Fields that the command ignores carry random noise.
    task automatic send_random_item();
        logic                                  cmd;
        logic signed [lapsf_pkg::SAMPLE_W-1:0] smp;
        logic signed [lapsf_pkg::COEFF_W-1:0]  kval;
        int                                    pick;
        cmd  = ($urandom_range(99) < 25) ? lapsf_pkg::CMD_COEFF : lapsf_pkg::CMD_FILTER;
        pick = $urandom_range(9);
        case (pick)
            0: begin
                smp = {1'b0, {(lapsf_pkg::SAMPLE_W-1){1'b1}}};
            end
            1: begin
                smp = {1'b1, {(lapsf_pkg::SAMPLE_W-1){1'b0}}};
            end
            2, 3, 4: begin
                smp = lapsf_pkg::SAMPLE_W'($signed($urandom_range(131071)) - 65536);
            end
            default: begin
                smp = lapsf_pkg::SAMPLE_W'($urandom);
            end
        endcase
        // Half the coefficients are mild so the output is not always pinned
        // at a rail; the rest span the whole Q1.15 range.
        if ($urandom_range(1) == 0) begin
            kval = lapsf_pkg::COEFF_W'($signed($urandom_range(32767)) - 16384);
        end else begin
            kval = lapsf_pkg::COEFF_W'($urandom);
        end
        send_item(cmd, smp, ($urandom_range(99) < 8), lapsf_pkg::INDEX_W'($urandom), kval);
    endtask

    // Drop valid, wait for every predicted result, then let the block finish
    // any trailing coefficient load or finish step before touching registers.
    task automatic quiesce();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [lapsf_pkg::APB_AW-3:0] reg_idx,
                             input logic [lapsf_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          orders [8];
        logic [31:0] order_val;
        orders = '{0, 16, 1, 31, 8, 17, 3, 12};

        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.command       = lapsf_pkg::CMD_FILTER;
        item_ch.sample_in     = '0;
        item_ch.restart       = 1'b0;
        item_ch.coeff_index   = '0;
        item_ch.coeff_value   = '0;
        result_ch.ready       = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset order of 5. With all coefficients zero
        // the lattice passes the input straight through, rails included.
        send_item(lapsf_pkg::CMD_FILTER, 24'sh7FFFFF, 1'b1, 4'hF, 16'sh7FFF);
        send_item(lapsf_pkg::CMD_FILTER, 24'sh800000, 1'b0, 4'h0, 16'sh8000);
        // Load extreme coefficients; sample and restart fields are noise.
        send_item(lapsf_pkg::CMD_COEFF, 24'sh7FFFFF, 1'b1, 4'd0, 16'sh8000);
        send_item(lapsf_pkg::CMD_COEFF, 24'sh800000, 1'b0, 4'd1, 16'sh7FFF);
        send_item(lapsf_pkg::CMD_COEFF, 24'sh555555, 1'b1, 4'd2, 16'sh4000);
        send_item(lapsf_pkg::CMD_COEFF, 24'shAAAAAA, 1'b0, 4'd4, -16'sd12345);
        // Stage 15 only matters once the order reaches the top.
        send_item(lapsf_pkg::CMD_COEFF, 24'sh000000, 1'b1, 4'd15, 16'sh7FFF);
        // Restart, then drive full scale to push every stage into saturation.
        send_item(lapsf_pkg::CMD_FILTER, 24'sh7FFFFF, 1'b1, 4'd7, 16'sh1234);
        send_item(lapsf_pkg::CMD_FILTER, 24'sh7FFFFF, 1'b0, 4'd3, 16'sh0000);
        send_item(lapsf_pkg::CMD_FILTER, 24'sh800000, 1'b0, 4'd9, 16'shFFFF);
        send_item(lapsf_pkg::CMD_FILTER, 24'sh000000, 1'b0, 4'd0, 16'sh0000);
        send_item(lapsf_pkg::CMD_FILTER, -24'sd1,     1'b0, 4'd5, 16'sh5A5A);
        send_item(lapsf_pkg::CMD_FILTER, 24'sh000001, 1'b1, 4'd8, 16'shA5A5);
        send_item(lapsf_pkg::CMD_FILTER, 24'sh123456, 1'b0, 4'd8, 16'shA5A5);

        // Random phases: each sets a new order (zero, the limits, above the
        // limit) and cycles through the four idle/stall patterns.
        for (int ph = 0; ph < 8; ph++) begin
            quiesce();
            order_val = 32'(orders[ph]);
            apb_write(lapsf_pkg::REG_ORDER, order_val);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        // Drain: every predicted result must arrive, then watch for strays.
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
